### design/gdad_pkg.sv
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared widths, limits, types and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // field widths
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 14;
  localparam int DAYS_WIDTH = 16;
  localparam int R400_W     = 9;
  localparam int QUOT_W     = 6;

  // calendar limits
  localparam logic [YEAR_W-1:0]  MIN_YEAR  = YEAR_W'(1600);
  localparam logic [YEAR_W-1:0]  MAX_YEAR  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FIRST_DAY = DAY_W'(1);
  localparam logic [DAY_W-1:0]   LAST_DAY  = DAY_W'(31);
  localparam logic [R400_W-1:0]  LAST_R400 = R400_W'(399);

  // year / 400 by reciprocal: floor(y * 5243 / 2^21) is exact below 2^14
  localparam int RECIP_400   = 5243;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = YEAR_W + 13;
  localparam int CYCLE_400   = 400;

  // calendar position: date plus year modulo 400
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [R400_W-1:0]  r400;
  } date_t;

  // result of one month step
  typedef struct packed {
    date_t                 date;
    logic [DAYS_WIDTH-1:0] days;
    logic                  done;
    logic                  ovf;
  } step_t;

  // leap year from year mod 400: divisible by 4, and not by 100 unless by 400
  function automatic logic leap_of(input logic [R400_W-1:0] r400);
    logic century;
    century = (r400 == R400_W'(100)) || (r400 == R400_W'(200)) ||
              (r400 == R400_W'(300));
    return (r400[1:0] == 2'b00) && !century;
  endfunction

  // month length; zero for month codes outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:                                   len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:                len = DAY_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                                  len = DAY_W'(31);
      default:                                len = '0;
    endcase
    return len;
  endfunction

endpackage

### design/gdad_in_if.sv
// ----------------------------------------------------------------------------
// gdad_in_if
// Input item channel: starting date and day count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdad_in_if;
  import gdad_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DAY_W-1:0]      in_day;
  logic [MONTH_W-1:0]    in_month;
  logic [YEAR_W-1:0]     in_year;
  logic [DAYS_WIDTH-1:0] days_to_add;

  modport source (output valid, output in_day, output in_month, output in_year,
                  output days_to_add, input ready);
  modport sink   (input valid, input in_day, input in_month, input in_year,
                  input days_to_add, output ready);
endinterface

### design/gdad_out_if.sv
// ----------------------------------------------------------------------------
// gdad_out_if
// Result item channel: resulting date and status flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdad_out_if;
  import gdad_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic               date_valid;
  logic               year_overflow;

  modport source (output valid, output out_day, output out_month, output out_year,
                  output date_valid, output year_overflow, input ready);
  modport sink   (input valid, input out_day, input out_month, input out_year,
                  input date_valid, input year_overflow, output ready);
endinterface

### design/gdad_month_step.sv
// ----------------------------------------------------------------------------
// gdad_month_step
// Shared step unit: advances a date by the rest of its month, or finishes
// inside the month when the remaining count fits, or pins at the range end.
// ----------------------------------------------------------------------------
module gdad_month_step (
  input  gdad_pkg::date_t                  cur,
  input  logic [gdad_pkg::DAYS_WIDTH-1:0]  days,
  output gdad_pkg::step_t                  step
);
  import gdad_pkg::*;

  logic [DAY_W-1:0]      dim;
  logic [DAY_W-1:0]      rem;
  logic [DAYS_WIDTH-1:0] rem_ext;

  // days left in the current month after the current day
  assign dim     = month_days(leap_of(cur.r400), cur.month);
  assign rem     = dim - cur.day;
  assign rem_ext = DAYS_WIDTH'(rem);

  always_comb begin
    step      = '0;
    step.date = cur;
    step.days = days;
    if (days > rem_ext) begin
      // jump to the first of the next month
      step.days     = days - rem_ext - DAYS_WIDTH'(1);
      step.date.day = FIRST_DAY;
      if (cur.month == DECEMBER) begin
        if (cur.year == MAX_YEAR) begin
          // would leave the year range: pin to the last representable day
          step.date.day   = LAST_DAY;
          step.date.month = DECEMBER;
          step.date.year  = MAX_YEAR;
          step.days       = '0;
          step.done       = 1'b1;
          step.ovf        = 1'b1;
        end else begin
          step.date.month = JANUARY;
          step.date.year  = cur.year + YEAR_W'(1);
          step.date.r400  = (cur.r400 == LAST_R400) ? '0 : cur.r400 + R400_W'(1);
        end
      end else begin
        step.date.month = cur.month + MONTH_W'(1);
      end
    end else begin
      // remaining count fits inside this month
      step.date.day = cur.day + DAY_W'(days);
      step.days     = '0;
      step.done     = 1'b1;
    end
  end

endmodule

### design/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date, one month per cycle through a shared
// step unit, with date validation and a hold at the end of the year range.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_ch    sink       valid / ready          in_day, in_month, in_year, days_to_add
//  out_ch   source     valid / ready          out_day, out_month, out_year,
//                                             date_valid, year_overflow
//
//  after accept the sequencer runs its quotient, remainder and check states, then
//  month steps until done, then the result stage; an invalid or held start skips the steps
//  in_ch.ready is high only while the sequencer is idle
//  a finished item sits in the output register; the next item may be taken
//  while it waits, and the sequencer holds its result if the register is full
//  rst_n is synchronous; it clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
  input  logic       clk,
  input  logic       rst_n,
  gdad_in_if.sink    in_ch,
  gdad_out_if.source out_ch
);
  import gdad_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_QUOT  = 6'b000010,
    ST_REM   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_STEP  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  date_t                 date_r, date_nxt;
  logic [DAYS_WIDTH-1:0] days_r, days_nxt;
  logic [QUOT_W-1:0]     quot_r, quot_nxt;
  logic                  valid_r, valid_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]      out_day_r, out_day_nxt;
  logic [MONTH_W-1:0]    out_month_r, out_month_nxt;
  logic [YEAR_W-1:0]     out_year_r, out_year_nxt;
  logic                  out_dv_r, out_dv_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic [PROD_W-1:0]     quot_prod;
  logic [YEAR_W:0]       cyc_prod;
  logic                  date_ok;
  logic                  slot_free;
  step_t                 step;

  // year / 400 by reciprocal, then the remainder
  assign quot_prod = PROD_W'(date_r.year) * PROD_W'(RECIP_400);
  assign cyc_prod  = (YEAR_W + 1)'(quot_r) * (YEAR_W + 1)'(CYCLE_400);

  // calendar validity of the starting date
  assign date_ok = (date_r.year >= MIN_YEAR) && (date_r.month >= JANUARY) &&
                   (date_r.month <= DECEMBER) && (date_r.day >= FIRST_DAY) &&
                   (date_r.day <= month_days(leap_of(date_r.r400), date_r.month));

  assign slot_free = !out_valid_r || out_ch.ready;

  // shared month step unit
  gdad_month_step u_step (
    .cur  (date_r),
    .days (days_r),
    .step (step)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    date_nxt      = date_r;
    days_nxt      = days_r;
    quot_nxt      = quot_r;
    valid_nxt     = valid_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_dv_nxt    = out_dv_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          date_nxt.day   = in_ch.in_day;
          date_nxt.month = in_ch.in_month;
          date_nxt.year  = in_ch.in_year;
          date_nxt.r400  = '0;
          days_nxt       = in_ch.days_to_add[DAYS_WIDTH-1:0];
          ovf_nxt        = 1'b0;
          state_nxt      = ST_QUOT;
        end
      end
      ST_QUOT: begin
        quot_nxt  = quot_prod[RECIP_SHIFT +: QUOT_W];
        state_nxt = ST_REM;
      end
      ST_REM: begin
        date_nxt.r400 = R400_W'(({1'b0, date_r.year}) - cyc_prod);
        state_nxt     = ST_CHECK;
      end
      ST_CHECK: begin
        valid_nxt = date_ok;
        if (!date_ok) begin
          state_nxt = ST_DONE;
        end else if (date_r.year > MAX_YEAR) begin
          // start beyond the range: held at once
          date_nxt.day   = LAST_DAY;
          date_nxt.month = DECEMBER;
          date_nxt.year  = MAX_YEAR;
          ovf_nxt        = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        date_nxt = step.date;
        days_nxt = step.days;
        ovf_nxt  = ovf_r | step.ovf;
        if (step.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_day_nxt   = date_r.day;
          out_month_nxt = date_r.month;
          out_year_nxt  = date_r.year;
          out_dv_nxt    = valid_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and output registers
  always_ff @(posedge clk) begin
    date_r      <= date_nxt;
    days_r      <= days_nxt;
    quot_r      <= quot_nxt;
    valid_r     <= valid_nxt;
    ovf_r       <= ovf_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_dv_r    <= out_dv_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // ports
  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_day       = out_day_r;
  assign out_ch.out_month     = out_month_r;
  assign out_ch.out_year      = out_year_r;
  assign out_ch.date_valid    = out_dv_r;
  assign out_ch.year_overflow = out_ovf_r;

  // an invalid date never reports overflow
  a_inval_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.date_valid |-> !out_ch.year_overflow)
    else $error("overflow flagged on an invalid date");

  // an overflowed result is pinned to the last day of the range
  a_ovf_pinned: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.year_overflow |->
      out_ch.out_day == LAST_DAY && out_ch.out_month == DECEMBER &&
      out_ch.out_year == MAX_YEAR)
    else $error("overflow result not held at the end of the range");

  // a valid result has a month in 1..12, a nonzero day and a year no later than the range end
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.date_valid |->
      out_ch.out_month >= JANUARY && out_ch.out_month <= DECEMBER &&
      out_ch.out_day >= FIRST_DAY && out_ch.out_year <= MAX_YEAR)
    else $error("valid result outside the calendar");

  // the sequencer only leaves its result stage when the output register takes it
  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && slot_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished item not loaded into the output register");

endmodule

### verif/gdad_checker.sv
// ----------------------------------------------------------------------------
// gdad_checker
// Watches both channels of the date adder. Each accepted input item is run
// through a calendar predictor, and the predicted date is queued. Each
// accepted result item is compared field by field with the oldest queued date.
// ----------------------------------------------------------------------------
module gdad_checker (
  input  logic clk,
  input  logic rst_n,
  gdad_in_if   in_ch,
  gdad_out_if  out_ch,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  // month lengths of a common year, index 0 unused
  localparam int MONTH_LEN [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               valid;
    logic               ovf;
  } date_result_t;

  date_result_t expected_dates [$];
  int           mismatch_count = 0;
  int           queued_dates   = 0;

  assign fail_count    = mismatch_count;
  assign pending_count = queued_dates;

  // length of a month, zero for month codes outside 1..12
  function automatic int days_in_month(input int unsigned yr, input int unsigned mo);
    if (mo < 1 || mo > 12) return 0;
    if (mo == 2 && ((yr % 400 == 0) || (yr % 4 == 0 && yr % 100 != 0))) return 29;
    return MONTH_LEN[mo];
  endfunction

  // validate the start date, then walk forward a month at a time
  function automatic date_result_t advance_date(input logic [DAY_W-1:0] d,
                                                input logic [MONTH_W-1:0] m,
                                                input logic [YEAR_W-1:0] y,
                                                input logic [DAYS_WIDTH-1:0] n);
    int unsigned  dd;
    int unsigned  mm;
    int unsigned  yy;
    int unsigned  left;
    int unsigned  dim;
    date_result_t r;
    dd    = 32'(d);
    mm    = 32'(m);
    yy    = 32'(y);
    left  = 32'(n);
    r.ovf = 1'b0;
    r.valid = (yy >= 1600) && (mm >= 1) && (mm <= 12) && (dd >= 1) &&
              (dd <= days_in_month(yy, mm));
    if (r.valid) begin
      // a valid start beyond the range is held at once
      if (yy > MAX_YEAR) begin
        r.ovf = 1'b1;
        dd    = 31;
        mm    = 12;
        yy    = 32'(MAX_YEAR);
        left  = 0;
      end
      while (left > 0) begin
        dim = days_in_month(yy, mm);
        if (dd + left > dim) begin
          left = left - (dim - dd + 1);
          dd   = 1;
          mm++;
          // year rolls only when stepping past december
          if (mm > 12) begin
            mm = 1;
            yy++;
            if (yy > MAX_YEAR) begin
              r.ovf = 1'b1;
              dd    = 31;
              mm    = 12;
              yy    = 32'(MAX_YEAR);
              left  = 0;
            end
          end
        end else begin
          dd   = dd + left;
          left = 0;
        end
      end
    end
    r.day   = DAY_W'(dd);
    r.month = MONTH_W'(mm);
    r.year  = YEAR_W'(yy);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: date result mismatch on %s: got %0d, expected %0d",
             $time, what, got, want);
    mismatch_count++;
  endtask

  // compare results first so a stray result is never matched to a fresh item
  always @(posedge clk) begin : watch
    date_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result with no item pending", 32'(out_ch.out_day), 0);
        end else begin
          want = expected_dates.pop_front();
          if (out_ch.out_day !== want.day)
            report_mismatch("out_day", 32'(out_ch.out_day), 32'(want.day));
          if (out_ch.out_month !== want.month)
            report_mismatch("out_month", 32'(out_ch.out_month), 32'(want.month));
          if (out_ch.out_year !== want.year)
            report_mismatch("out_year", 32'(out_ch.out_year), 32'(want.year));
          if (out_ch.date_valid !== want.valid)
            report_mismatch("date_valid", 32'(out_ch.date_valid), 32'(want.valid));
          if (out_ch.year_overflow !== want.ovf)
            report_mismatch("year_overflow", 32'(out_ch.year_overflow), 32'(want.ovf));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_dates.push_back(advance_date(in_ch.in_day, in_ch.in_month,
                                              in_ch.in_year, in_ch.days_to_add));
      end
    end
    queued_dates = expected_dates.size();
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the date adder with directed calendar corners and then random
// dates over several idle and stall mixes, including a long output hold-off.
// A checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdad_pkg::*;

  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_req;
  int   cycle_count;

  gdad_in_if  in_ch ();
  gdad_out_if out_ch ();

  gregorian_date_add_days i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gdad_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // offer one item after random idle cycles, return at the negedge after accept
  task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0] y, input logic [DAYS_WIDTH-1:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_day      <= d;
    in_ch.in_month    <= m;
    in_ch.in_year     <= y;
    in_ch.days_to_add <= n;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // mostly well-formed dates with short spans, some raw noise
  task automatic send_random_date();
    logic [DAY_W-1:0]      d;
    logic [MONTH_W-1:0]    m;
    logic [YEAR_W-1:0]     y;
    logic [DAYS_WIDTH-1:0] n;
    int                    pick;
    if ($urandom_range(99) < 15) begin
      d = DAY_W'($urandom);
      m = MONTH_W'($urandom);
      y = YEAR_W'($urandom);
      n = DAYS_WIDTH'($urandom_range(3000, 0));
    end else begin
      pick = $urandom_range(99);
      if (pick < 70)      y = YEAR_W'($urandom_range(9999, 1600));
      else if (pick < 80) y = YEAR_W'($urandom_range(9999, 9985));
      else if (pick < 88) y = YEAR_W'($urandom_range(1610, 1600));
      else if (pick < 95) y = YEAR_W'($urandom_range(2404, 1896));
      else                y = YEAR_W'($urandom_range(16383, 10000));
      m = MONTH_W'($urandom_range(12, 1));
      if ($urandom_range(99) < 80) d = DAY_W'($urandom_range(28, 1));
      else                         d = DAY_W'($urandom_range(31, 29));
      pick = $urandom_range(99);
      if (pick < 60)      n = DAYS_WIDTH'($urandom_range(60, 0));
      else if (pick < 85) n = DAYS_WIDTH'($urandom_range(1500, 0));
      else if (pick < 95) n = DAYS_WIDTH'($urandom);
      else begin
        case ($urandom_range(4))
          0:       n = '0;
          1:       n = '1;
          2:       n = DAYS_WIDTH'(1);
          3:       n = DAYS_WIDTH'(365);
          default: n = DAYS_WIDTH'(366);
        endcase
      end
    end
    send_date(d, m, y, n);
  endtask

  // sender pauses until every predicted result has arrived
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count,
                           input bit with_hold);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 40) hold_req++;
      send_random_date();
    end
    wait_all_results();
  endtask

  // stimulus and verdict
  initial begin : stimulus
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_day      = '0;
    in_ch.in_month    = '0;
    in_ch.in_year     = '0;
    in_ch.days_to_add = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed calendar corners
    send_date(5'd1,  4'd1,  14'd1600,  16'd0);      // earliest valid date, no days
    send_date(5'd31, 4'd12, 14'd9999,  16'd0);      // last date in range
    send_date(5'd31, 4'd12, 14'd9999,  16'd1);      // steps past the range
    send_date(5'd31, 4'd12, 14'd2023,  16'd1);      // new year rollover
    send_date(5'd1,  4'd12, 14'd2023,  16'd30);     // december without rollover
    send_date(5'd28, 4'd2,  14'd2024,  16'd1);      // leap february
    send_date(5'd28, 4'd2,  14'd2023,  16'd1);      // common february
    send_date(5'd29, 4'd2,  14'd1900,  16'd5);      // century not leap
    send_date(5'd29, 4'd2,  14'd2000,  16'd365);    // 400-year leap
    send_date(5'd0,  4'd5,  14'd2010,  16'd10);     // day zero
    send_date(5'd10, 4'd0,  14'd2010,  16'd10);     // month zero
    send_date(5'd10, 4'd13, 14'd2010,  16'd10);     // month thirteen
    send_date(5'd31, 4'd4,  14'd2010,  16'd3);      // day past short month
    send_date(5'd31, 4'd12, 14'd1599,  16'd1);      // year below range
    send_date(5'd1,  4'd1,  14'd16383, 16'd0);      // valid start above range
    send_date(5'd31, 4'd12, 14'd10000, 16'd7);
    send_date(5'd1,  4'd1,  14'd1600,  16'hFFFF);   // longest span from the start
    send_date(5'd1,  4'd1,  14'd9900,  16'hFFFF);   // long span into the limit
    send_date(5'd31, 4'd15, 14'd16383, 16'hFFFF);   // all ones, invalid
    send_date(5'd0,  4'd0,  14'd0,     16'd0);      // all zeros, invalid
    send_date(5'd15, 4'd6,  14'd2020,  16'd12345);
    send_date(5'd30, 4'd11, 14'd8191,  16'd400);
    wait_all_results();

    // random phases: clean with a long output hold-off, then idle and stall mixes
    run_phase(0,  0,  240, 1'b1);
    run_phase(73, 0,  235, 1'b0);
    run_phase(0,  73, 235, 1'b0);
    run_phase(34, 34, 240, 1'b0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
